// File: src/rtc_pkg.sv
package rtc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ID_BITS   = 16;
  localparam int CRD_W     = 32;
  localparam int EDGE_W    = CRD_W + 1;
  localparam int OPND_W    = EDGE_W + 1;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int CRS_W     = 2 * EDGE_W;
  localparam int ACC_W     = 104;
  localparam int DIV_W     = 136;
  localparam int T_BITS    = 31;
  localparam int QUO_W     = T_BITS + 1;
  localparam int BARY_W    = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_DIR_X     = 3'd3,
    REG_DIR_Y     = 3'd4,
    REG_DIR_Z     = 3'd5,
    REG_MIN_DIST  = 3'd6,
    REG_DET_THR   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] a_x;
    logic signed [CRD_W-1:0] a_y;
    logic signed [CRD_W-1:0] a_z;
    logic signed [CRD_W-1:0] b_x;
    logic signed [CRD_W-1:0] b_y;
    logic signed [CRD_W-1:0] b_z;
    logic signed [CRD_W-1:0] c_x;
    logic signed [CRD_W-1:0] c_y;
    logic signed [CRD_W-1:0] c_z;
    logic [ID_BITS-1:0]      triangle_id;
    logic                    last;
  } tri_in_t;

  typedef struct packed {
    logic                hit;
    logic [ID_BITS-1:0]  hit_id;
    logic [T_BITS-1:0]   hit_distance;
    logic [BARY_W-1:0]   bary_u;
    logic [BARY_W-1:0]   bary_v;
  } hit_out_t;

  typedef struct packed {
    logic [CRD_W-1:0]  origin_x;
    logic [CRD_W-1:0]  origin_y;
    logic [CRD_W-1:0]  origin_z;
    logic [CRD_W-1:0]  dir_x;
    logic [CRD_W-1:0]  dir_y;
    logic [CRD_W-1:0]  dir_z;
    logic [T_BITS-1:0] min_dist;
    logic [T_BITS-1:0] det_thr;
  } ray_cfg_t;

  // Edge vectors of one triangle, ready for the arithmetic back end
  typedef struct packed {
    logic [2:0][EDGE_W-1:0] e1;
    logic [2:0][EDGE_W-1:0] e2;
    logic [2:0][EDGE_W-1:0] s;
    logic [ID_BITS-1:0]     id;
    logic                   last;
  } work_t;

endpackage

// File: src/ray_triangle_closest_hit_top.sv
// Closest-hit ray/triangle test over a batch of triangles in Q16.16. Set the
// ray with the configuration port (origin, direction, minimum distance and
// determinant threshold) while the block is idle, then stream triangles; the
// triangle flagged last yields one result, the nearest hit or an all-zero miss,
// and the batch state is then cleared. In the back end a rejected triangle
// skips the divider and one whose distance falls outside the window skips the
// divisions for u and v; on the last item the result register is loaded in the
// final state, which stretches only while an earlier result waits.
// The back end uses the single shared 34x34 multiplier, which works through
// 36 partial products per triangle, and the one-bit-per-cycle divider for
// t, u and v. A two-entry queue lets the front take further triangles while the
// back end is busy, and the result register lets the next batch start while a
// result still waits for its transfer.
module ray_triangle_closest_hit_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rtc_pkg::tri_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rtc_pkg::hit_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtc_pkg::CRD_W-1:0]         cfg_data
);
  import rtc_pkg::*;

  ray_cfg_t cfg_r;
  logic     push_valid, push_ready, pop_valid, pop_ready;
  work_t    push_data, pop_data;

  assign cfg_ready = 1'b1;

  // Register file for the ray
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.origin_z <= '0;
      cfg_r.dir_x    <= CRD_W'(1) << FRAC_BITS;
      cfg_r.dir_y    <= '0;
      cfg_r.dir_z    <= '0;
      cfg_r.min_dist <= T_BITS'(7);
      cfg_r.det_thr  <= T_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: cfg_r.origin_x <= cfg_data;
        REG_ORIGIN_Y: cfg_r.origin_y <= cfg_data;
        REG_ORIGIN_Z: cfg_r.origin_z <= cfg_data;
        REG_DIR_X:    cfg_r.dir_x    <= cfg_data;
        REG_DIR_Y:    cfg_r.dir_y    <= cfg_data;
        REG_DIR_Z:    cfg_r.dir_z    <= cfg_data;
        REG_MIN_DIST: cfg_r.min_dist <= cfg_data[T_BITS-1:0];
        REG_DET_THR:  cfg_r.det_thr  <= cfg_data[T_BITS-1:0];
        default: ;
      endcase
    end
  end

  rtc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rtc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: src/rtc_front.sv
module rtc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rtc_pkg::tri_in_t  in_data,
  input  rtc_pkg::ray_cfg_t cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output rtc_pkg::work_t    push_data
);
  import rtc_pkg::*;

  logic  f_v_r;
  work_t w_r;
  work_t w_nxt;

  function automatic logic [EDGE_W-1:0] dif(input logic [CRD_W-1:0] x,
                                           input logic [CRD_W-1:0] y);
    return {x[CRD_W-1], x} - {y[CRD_W-1], y};
  endfunction

  // Form the edges and the origin offset from vertex A
  always_comb begin
    w_nxt.e1[0] = dif(in_data.b_x, in_data.a_x);
    w_nxt.e1[1] = dif(in_data.b_y, in_data.a_y);
    w_nxt.e1[2] = dif(in_data.b_z, in_data.a_z);
    w_nxt.e2[0] = dif(in_data.c_x, in_data.a_x);
    w_nxt.e2[1] = dif(in_data.c_y, in_data.a_y);
    w_nxt.e2[2] = dif(in_data.c_z, in_data.a_z);
    w_nxt.s[0]  = dif(cfg.origin_x, in_data.a_x);
    w_nxt.s[1]  = dif(cfg.origin_y, in_data.a_y);
    w_nxt.s[2]  = dif(cfg.origin_z, in_data.a_z);
    w_nxt.id    = in_data.triangle_id;
    w_nxt.last  = in_data.last;
  end

  assign in_stall   = f_v_r && !push_ready;
  assign push_valid = f_v_r;
  assign push_data  = w_r;

  // Hold one prepared triangle until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      f_v_r <= 1'b1;
    end else if (push_ready) begin
      f_v_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      w_r <= w_nxt;
    end
  end

endmodule

// File: src/rtc_queue.sv
module rtc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rtc_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rtc_pkg::work_t pop_data
);
  import rtc_pkg::*;

  work_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill count on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/rtc_back.sv
module rtc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rtc_pkg::ray_cfg_t cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  rtc_pkg::work_t    pop_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rtc_pkg::hit_out_t out_data
);
  import rtc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CROSS, ST_DOT, ST_DRAIN, ST_EVAL, ST_DIV, ST_FIN
  } state_t;

  typedef enum logic [1:0] {DV_T, DV_U, DV_V} dsel_t;

  state_t st_r;
  dsel_t  dsel_r;
  logic [4:0] cnt_r;

  logic [2:0][EDGE_W-1:0] e1_r, e2_r, s_r;
  logic [ID_BITS-1:0]     id_r;
  logic                   last_r;

  logic signed [CRS_W-1:0] crs_r [6];
  logic signed [ACC_W-1:0] dot_r [4];

  logic signed [PROD_W-1:0] prod_r;
  logic       pv_r, pneg_r, phi_r, pcrs_r;
  logic [2:0] pdst_r;

  logic [ACC_W-1:0] det_r, nu_r, nv_r;
  logic [DIV_W-1:0] rem_r, dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [T_BITS-1:0] t_r;
  logic [BARY_W-1:0] u_r;

  logic [T_BITS-1:0]  best_dist_r;
  logic [ID_BITS-1:0] best_id_r;
  logic [BARY_W-1:0]  best_u_r, best_v_r;
  logic               found_r;

  logic     out_valid_r;
  hit_out_t out_data_r;

  // Multiplier operand selection
  logic [2:0][EDGE_W-1:0] dvec, xv, yv;
  logic signed [OPND_W-1:0] a_op, b_op;
  logic       m_neg, m_hi, m_crs;
  logic [2:0] m_dst;
  logic       cr_q;
  logic [2:0] cr_r, dt_r;
  logic [1:0] k, k1, k2, g;
  logic [2:0] bidx;
  logic [CRS_W-1:0] big;
  logic [EDGE_W-1:0] sml;

  // Sign normalisation and acceptance
  logic             neg;
  logic [ACC_W-1:0] det_a, nu_a, nv_a, nt_a, thr_sh, sum_uv;
  logic             acc_ok;

  // Divider step
  logic             ge;
  logic [QUO_W-1:0] q_fin;
  logic [T_BITS-1:0] t_fin;

  function automatic logic [1:0] rot1(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] rot2(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  assign dvec[0] = {cfg.dir_x[CRD_W-1], cfg.dir_x};
  assign dvec[1] = {cfg.dir_y[CRD_W-1], cfg.dir_y};
  assign dvec[2] = {cfg.dir_z[CRD_W-1], cfg.dir_z};

  // Pick one partial product per cycle for the shared multiplier
  always_comb begin
    a_op  = '0;
    b_op  = '0;
    m_neg = 1'b0;
    m_hi  = 1'b0;
    m_crs = 1'b0;
    m_dst = '0;
    cr_q  = (cnt_r >= 5'd6);
    cr_r  = cr_q ? 3'(cnt_r - 5'd6) : cnt_r[2:0];
    xv    = cr_q ? s_r : dvec;
    yv    = cr_q ? e1_r : e2_r;
    if (cnt_r >= 5'd18) begin
      g = 2'd3; dt_r = 3'(cnt_r - 5'd18);
    end else if (cnt_r >= 5'd12) begin
      g = 2'd2; dt_r = 3'(cnt_r - 5'd12);
    end else if (cnt_r >= 5'd6) begin
      g = 2'd1; dt_r = 3'(cnt_r - 5'd6);
    end else begin
      g = 2'd0; dt_r = cnt_r[2:0];
    end
    k    = (st_r == ST_CROSS) ? cr_r[2:1] : dt_r[2:1];
    k1   = rot1(k);
    k2   = rot2(k);
    bidx = {1'b0, k} + (g[1] ? 3'd3 : 3'd0);
    big  = crs_r[bidx];
    case (g)
      2'd0:    sml = e1_r[k];
      2'd1:    sml = s_r[k];
      2'd2:    sml = dvec[k];
      default: sml = e2_r[k];
    endcase
    if (st_r == ST_CROSS) begin
      m_crs = 1'b1;
      m_dst = {1'b0, k} + (cr_q ? 3'd3 : 3'd0);
      m_neg = cr_r[0];
      if (!cr_r[0]) begin
        a_op = {xv[k1][EDGE_W-1], xv[k1]};
        b_op = {yv[k2][EDGE_W-1], yv[k2]};
      end else begin
        a_op = {xv[k2][EDGE_W-1], xv[k2]};
        b_op = {yv[k1][EDGE_W-1], yv[k1]};
      end
    end else begin
      m_dst = {1'b0, g};
      m_hi  = dt_r[0];
      a_op  = dt_r[0] ? {big[CRS_W-1], big[CRS_W-1:EDGE_W]} : {1'b0, big[EDGE_W-1:0]};
      b_op  = {sml[EDGE_W-1], sml};
    end
  end

  // Normalise signs, then test the determinant threshold and the barycentric window
  always_comb begin
    neg    = dot_r[0][ACC_W-1];
    det_a  = neg ? -dot_r[0] : dot_r[0];
    nu_a   = neg ? -dot_r[1] : dot_r[1];
    nv_a   = neg ? -dot_r[2] : dot_r[2];
    nt_a   = neg ? -dot_r[3] : dot_r[3];
    thr_sh = ACC_W'(cfg.det_thr) << (2 * FRAC_BITS);
    sum_uv = nu_a + nv_a;
    acc_ok = (det_a != '0) && (det_a >= thr_sh) && !nu_a[ACC_W-1] &&
             !nv_a[ACC_W-1] && !nt_a[ACC_W-1] && (sum_uv <= det_a);
  end

  assign ge    = (rem_r >= dsh_r);
  assign q_fin = {quo_r[QUO_W-2:0], ge};
  assign t_fin = q_fin[QUO_W-1] ? {T_BITS{1'b1}} : q_fin[T_BITS-1:0];

  assign pop_ready = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    // Accumulate the product issued last cycle
    if (pv_r) begin
      if (pcrs_r) begin
        crs_r[pdst_r] <= crs_r[pdst_r] + CRS_W'(pneg_r ? -prod_r : prod_r);
      end else begin
        dot_r[pdst_r[1:0]] <= dot_r[pdst_r[1:0]] +
          ({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} << (phi_r ? EDGE_W : 0));
      end
    end
    prod_r <= a_op * b_op;
    pneg_r <= m_neg;
    phi_r  <= m_hi;
    pcrs_r <= m_crs;
    pdst_r <= m_dst;

    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      best_dist_r <= {T_BITS{1'b1}};
      best_id_r   <= '0;
      best_u_r    <= '0;
      best_v_r    <= '0;
      dsel_r      <= DV_T;
    end else begin
      // Load the result register on the last item, release it on a transfer
      if ((st_r == ST_FIN) && last_r && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      pv_r <= (st_r == ST_CROSS) || (st_r == ST_DOT);
      case (st_r)
        ST_IDLE: begin
          if (pop_valid) begin
            e1_r   <= pop_data.e1;
            e2_r   <= pop_data.e2;
            s_r    <= pop_data.s;
            id_r   <= pop_data.id;
            last_r <= pop_data.last;
            for (int i = 0; i < 6; i++) crs_r[i] <= '0;
            for (int i = 0; i < 4; i++) dot_r[i] <= '0;
            cnt_r  <= '0;
            st_r   <= ST_CROSS;
          end
        end
        ST_CROSS: begin
          if (cnt_r == 5'd11) begin
            cnt_r <= '0;
            st_r  <= ST_DOT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_DOT: begin
          if (cnt_r == 5'd23) begin
            cnt_r <= '0;
            st_r  <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_DRAIN: begin
          st_r <= ST_EVAL;
        end
        ST_EVAL: begin
          det_r <= det_a;
          nu_r  <= nu_a;
          nv_r  <= nv_a;
          if (acc_ok) begin
            rem_r  <= DIV_W'(nt_a) << FRAC_BITS;
            dsh_r  <= DIV_W'(det_a) << T_BITS;
            quo_r  <= '0;
            cnt_r  <= 5'(QUO_W - 1);
            dsel_r <= DV_T;
            st_r   <= ST_DIV;
          end else begin
            st_r <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (cnt_r == '0) begin
            // Last quotient bit: settle t, u or v
            quo_r <= '0;
            case (dsel_r)
              DV_T: begin
                if ((t_fin >= cfg.min_dist) && (t_fin <= best_dist_r)) begin
                  t_r    <= t_fin;
                  rem_r  <= DIV_W'(nu_r) << FRAC_BITS;
                  dsh_r  <= DIV_W'(det_r) << FRAC_BITS;
                  cnt_r  <= 5'(BARY_W - 1);
                  dsel_r <= DV_U;
                end else begin
                  st_r <= ST_FIN;
                end
              end
              DV_U: begin
                u_r    <= q_fin[BARY_W-1:0];
                rem_r  <= DIV_W'(nv_r) << FRAC_BITS;
                dsh_r  <= DIV_W'(det_r) << FRAC_BITS;
                cnt_r  <= 5'(BARY_W - 1);
                dsel_r <= DV_V;
              end
              default: begin
                best_dist_r <= t_r;
                best_id_r   <= id_r;
                best_u_r    <= u_r;
                best_v_r    <= q_fin[BARY_W-1:0];
                found_r     <= 1'b1;
                st_r        <= ST_FIN;
              end
            endcase
          end else begin
            // One quotient bit per cycle
            if (ge) rem_r <= rem_r - dsh_r;
            dsh_r <= dsh_r >> 1;
            quo_r <= q_fin;
            cnt_r <= cnt_r - 5'd1;
          end
        end
        ST_FIN: begin
          // On the last item, report the batch and clear it once the output register is free
          if (!last_r) begin
            st_r <= ST_IDLE;
          end else if (!out_valid_r || !out_stall) begin
            out_data_r.hit          <= found_r;
            out_data_r.hit_id       <= found_r ? best_id_r : '0;
            out_data_r.hit_distance <= found_r ? best_dist_r : '0;
            out_data_r.bary_u       <= found_r ? best_u_r : '0;
            out_data_r.bary_v       <= found_r ? best_v_r : '0;
            found_r     <= 1'b0;
            best_dist_r <= {T_BITS{1'b1}};
            best_id_r   <= '0;
            best_u_r    <= '0;
            best_v_r    <= '0;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/rtc_checker.sv
module rtc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input rtc_pkg::hit_out_t out_data
);
  import rtc_pkg::*;

  // A stalled result stays in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing is offered straight after reset
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");

  // A miss carries all-zero fields
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_id == '0 &&
      out_data.hit_distance == '0 && out_data.bary_u == '0 && out_data.bary_v == '0)
    else $error("miss with non-zero fields");

  // Barycentric weights of a hit stay inside the triangle
  a_bary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |->
      ({1'b0, out_data.bary_u} + {1'b0, out_data.bary_v}) <= ((BARY_W + 1)'(1) << FRAC_BITS))
    else $error("barycentric weights outside triangle");

endmodule

bind ray_triangle_closest_hit_top rtc_checker u_rtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/ray_triangle_closest_hit_checker.sv
module ray_triangle_closest_hit_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  rtc_pkg::tri_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  rtc_pkg::hit_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtc_pkg::CRD_W-1:0]     cfg_data,
  output int                            pending,
  output int                            errors,
  output int                            hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtc_pkg::*;

  typedef logic signed [159:0] wide_t;

  // Ray set-up as seen on the configuration port
  logic signed [CRD_W-1:0] ray_org [3];
  logic signed [CRD_W-1:0] ray_dir [3];
  logic [T_BITS-1:0]       min_dist;
  logic [T_BITS-1:0]       det_thr;

  // Closest hit of the open batch
  logic [31:0]         near_dist;
  logic [ID_BITS-1:0]  near_id;
  logic [BARY_W-1:0]   near_u;
  logic [BARY_W-1:0]   near_v;
  logic                near_found;

  hit_out_t expected_hits [$];

  assign pending = expected_hits.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic clear_batch();
    near_dist  = 32'h7FFF_FFFF;
    near_id    = '0;
    near_u     = '0;
    near_v     = '0;
    near_found = 1'b0;
  endtask

  // Exact Moller-Trumbore on one triangle, then update the running minimum
  task automatic predict_triangle(input tri_in_t tri_item);
    logic signed [CRD_W-1:0] va [3];
    logic signed [CRD_W-1:0] vb [3];
    logic signed [CRD_W-1:0] vc [3];
    wide_t e1 [3];
    wide_t e2 [3];
    wide_t sv [3];
    wide_t dv [3];
    wide_t p [3];
    wide_t q [3];
    wide_t det, nu, nv, nt, thr, quo;
    logic [31:0] tq;
    hit_out_t res;
    va = '{tri_item.a_x, tri_item.a_y, tri_item.a_z};
    vb = '{tri_item.b_x, tri_item.b_y, tri_item.b_z};
    vc = '{tri_item.c_x, tri_item.c_y, tri_item.c_z};
    for (int k = 0; k < 3; k++) begin
      e1[k] = wide_t'($signed(vb[k])) - wide_t'($signed(va[k]));
      e2[k] = wide_t'($signed(vc[k])) - wide_t'($signed(va[k]));
      sv[k] = wide_t'($signed(ray_org[k])) - wide_t'($signed(va[k]));
      dv[k] = wide_t'($signed(ray_dir[k]));
    end
    p[0] = dv[1] * e2[2] - dv[2] * e2[1];
    p[1] = dv[2] * e2[0] - dv[0] * e2[2];
    p[2] = dv[0] * e2[1] - dv[1] * e2[0];
    q[0] = sv[1] * e1[2] - sv[2] * e1[1];
    q[1] = sv[2] * e1[0] - sv[0] * e1[2];
    q[2] = sv[0] * e1[1] - sv[1] * e1[0];
    det = p[0] * e1[0] + p[1] * e1[1] + p[2] * e1[2];
    nu  = p[0] * sv[0] + p[1] * sv[1] + p[2] * sv[2];
    nv  = q[0] * dv[0] + q[1] * dv[1] + q[2] * dv[2];
    nt  = q[0] * e2[0] + q[1] * e2[1] + q[2] * e2[2];
    // Fold the sign of the determinant into all four terms
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    thr = wide_t'({1'b0, det_thr}) <<< (2 * FRAC_BITS);
    if (det != 0 && det >= thr && nu >= 0 && nv >= 0 && nt >= 0 && nu + nv <= det) begin
      quo = (nt <<< FRAC_BITS) / det;
      tq  = (quo > 160'sh7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      if (tq >= {1'b0, min_dist} && tq <= near_dist) begin
        near_dist  = tq;
        near_id    = tri_item.triangle_id;
        quo        = (nu <<< FRAC_BITS) / det;
        near_u     = (quo > (160'sd1 <<< FRAC_BITS)) ? BARY_W'(1 << FRAC_BITS) : quo[BARY_W-1:0];
        quo        = (nv <<< FRAC_BITS) / det;
        near_v     = (quo > (160'sd1 <<< FRAC_BITS)) ? BARY_W'(1 << FRAC_BITS) : quo[BARY_W-1:0];
        near_found = 1'b1;
      end
    end
    if (tri_item.last) begin
      res = '0;
      if (near_found) begin
        res.hit          = 1'b1;
        res.hit_id       = near_id;
        res.hit_distance = near_dist[T_BITS-1:0];
        res.bary_u       = near_u;
        res.bary_v       = near_v;
      end
      expected_hits = {expected_hits, res};
      clear_batch();
    end
  endtask

  // Track configuration, predict on each input transfer, compare each result
  always @(posedge clk) begin
    hit_out_t want;
    if (!rst_n) begin
      ray_org  = '{default: '0};
      ray_dir  = '{32'sd65536, 32'sd0, 32'sd0};
      min_dist = 31'd7;
      det_thr  = 31'd1;
      clear_batch();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ORIGIN_X: ray_org[0] = cfg_data;
          REG_ORIGIN_Y: ray_org[1] = cfg_data;
          REG_ORIGIN_Z: ray_org[2] = cfg_data;
          REG_DIR_X:    ray_dir[0] = cfg_data;
          REG_DIR_Y:    ray_dir[1] = cfg_data;
          REG_DIR_Z:    ray_dir[2] = cfg_data;
          REG_MIN_DIST: min_dist   = cfg_data[T_BITS-1:0];
          REG_DET_THR:  det_thr    = cfg_data[T_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_triangle(in_data);
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report("unexpected result", 64'(out_data), 64'(0));
        end else begin
          want = expected_hits.pop_front();
          if (out_data.hit) hits_seen++;
          if (out_data.hit != want.hit)
            report("hit", 64'(out_data.hit), 64'(want.hit));
          if (out_data.hit_id != want.hit_id)
            report("hit_id", 64'(out_data.hit_id), 64'(want.hit_id));
          if (out_data.hit_distance != want.hit_distance)
            report("hit_distance", 64'(out_data.hit_distance), 64'(want.hit_distance));
          if (out_data.bary_u != want.bary_u)
            report("bary_u", 64'(out_data.bary_u), 64'(want.bary_u));
          if (out_data.bary_v != want.bary_v)
            report("bary_v", 64'(out_data.bary_v), 64'(want.bary_v));
        end
      end
    end
  end

  initial begin
    errors    = 0;
    hits_seen = 0;
  end

endmodule

// File: bench/ray_triangle_closest_hit_top_tb.sv
module ray_triangle_closest_hit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtc_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int Q_ONE      = 1 << FRAC_BITS;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tri_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  hit_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CRD_W-1:0]     cfg_data = '0;

  int pending, errors, hits_seen;
  int triangles_sent = 0;
  int batches_sent = 0;
  int ray_settings = 1;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;

  // Ray currently programmed, used to aim triangles
  logic signed [31:0] cur_org [3] = '{0, 0, 0};
  logic signed [31:0] cur_dir [3] = '{Q_ONE, 0, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_triangle_closest_hit_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ray_triangle_closest_hit_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .errors, .hits_seen
  );

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= REG_ORIGIN_Z) cur_org[2'(idx)] = value;
    else if (idx <= REG_DIR_Z) cur_dir[2'(idx - REG_DIR_X)] = value;
    @(posedge clk);
  endtask

  // Offer one triangle, hold it until the transfer, then draw the gap
  task automatic send_triangle(input tri_in_t tri_item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= tri_item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    triangles_sent++;
    if (tri_item.last) batches_sent++;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic tri_in_t make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                       input int id, input bit last);
    tri_in_t tri_item;
    tri_item = '{ax, ay, az, bx, by, bz, cx, cy, cz, id[ID_BITS-1:0], last};
    return tri_item;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Triangle around a point on the current ray, sometimes behind the origin
  function automatic tri_in_t aimed_tri(input bit last);
    longint tpar;
    int pt [3];
    tri_in_t tri_item;
    tpar = longint'($urandom_range(0, 1 << 20)) - (($urandom_range(0, 7) == 0) ? 200000 : 0);
    for (int k = 0; k < 3; k++)
      pt[k] = int'(longint'(cur_org[k]) + ((tpar * longint'(cur_dir[k])) >>> FRAC_BITS));
    tri_item = make_tri(pt[0] + jitter(1 << 19), pt[1] + jitter(1 << 19),
                        pt[2] + jitter(1 << 19),
                        pt[0] + jitter(1 << 19), pt[1] + jitter(1 << 19),
                        pt[2] + jitter(1 << 19),
                        pt[0] + jitter(1 << 19), pt[1] + jitter(1 << 19),
                        pt[2] + jitter(1 << 19),
                        $urandom, last);
    return tri_item;
  endfunction

  function automatic tri_in_t noise_tri(input bit last);
    return make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, last);
  endfunction

  // Drop the input, then wait until every result is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Receiver: stall before every result for a drawn gap, none in the quiet phase and one long hold when asked
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (long_hold) begin
        gap = 600;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n, len;
    bit aim;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed batches on the reset ray (origin 0, direction +x)
    send_triangle(make_tri(2*Q_ONE, -Q_ONE, -Q_ONE, 2*Q_ONE, Q_ONE, -Q_ONE,
                           2*Q_ONE, -Q_ONE, Q_ONE, 'hFFFF, 1'b1));
    send_triangle(make_tri(2*Q_ONE, 5*Q_ONE, 5*Q_ONE, 2*Q_ONE, 6*Q_ONE, 5*Q_ONE,
                           2*Q_ONE, 5*Q_ONE, 6*Q_ONE, 3, 1'b1));
    send_triangle(make_tri(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                           Q_ONE, Q_ONE, Q_ONE, 4, 1'b1));
    send_triangle(make_tri(-2*Q_ONE, -Q_ONE, -Q_ONE, -2*Q_ONE, Q_ONE, -Q_ONE,
                           -2*Q_ONE, -Q_ONE, Q_ONE, 5, 1'b1));
    // Equal distance: the later triangle wins
    send_triangle(make_tri(3*Q_ONE, -Q_ONE, -Q_ONE, 3*Q_ONE, Q_ONE, -Q_ONE,
                           3*Q_ONE, -Q_ONE, Q_ONE, 1, 1'b0));
    send_triangle(make_tri(3*Q_ONE, -Q_ONE, -Q_ONE, 3*Q_ONE, Q_ONE, -Q_ONE,
                           3*Q_ONE, -Q_ONE, Q_ONE, 2, 1'b1));
    // Nearer first, farther second, then a hit exactly on a vertex
    send_triangle(make_tri(Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE,
                           Q_ONE, Q_ONE, -Q_ONE, 7, 1'b0));
    send_triangle(make_tri(4*Q_ONE, -Q_ONE, -Q_ONE, 4*Q_ONE, Q_ONE, -Q_ONE,
                           4*Q_ONE, -Q_ONE, Q_ONE, 8, 1'b0));
    send_triangle(make_tri(5*Q_ONE, 0, -Q_ONE, 5*Q_ONE, 0, 0,
                           5*Q_ONE, Q_ONE, 0, 9, 1'b1));
    // Below the minimum distance, and on the origin itself
    send_triangle(make_tri(2, -Q_ONE, -Q_ONE, 2, Q_ONE, -Q_ONE, 2, -Q_ONE, Q_ONE, 10, 1'b1));
    send_triangle(make_tri(0, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 11, 1'b1));
    // Extreme coordinates
    send_triangle(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1));
    send_triangle(make_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 12, 1'b1));
    // Very far plane to push t towards saturation
    send_triangle(make_tri(32'h7FFF_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 13, 1'b1));
    drain();

    // Extremes: tiny thresholds, then huge ones, with an extreme ray
    cfg_write(REG_MIN_DIST, 32'h0);
    cfg_write(REG_DET_THR, 32'h0);
    send_triangle(make_tri(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                           14, 1'b1));
    send_triangle(make_tri(0, -Q_ONE, -Q_ONE, 0, Q_ONE, -Q_ONE, 0, -Q_ONE, Q_ONE, 15, 1'b1));
    drain();
    cfg_write(REG_ORIGIN_X, 32'h8000_0000);
    cfg_write(REG_ORIGIN_Y, 32'h7FFF_FFFF);
    cfg_write(REG_ORIGIN_Z, 32'h8000_0000);
    cfg_write(REG_DIR_X, 32'h7FFF_FFFF);
    cfg_write(REG_DIR_Y, 32'h8000_0000);
    cfg_write(REG_DIR_Z, 32'h7FFF_FFFF);
    cfg_write(REG_MIN_DIST, 32'h7FFF_FFFF);
    cfg_write(REG_DET_THR, 32'h7FFF_FFFF);
    ray_settings += 2;
    for (int i = 0; i < 30; i++) send_triangle(noise_tri($urandom_range(0, 3) == 0));
    send_triangle(noise_tri(1'b1));
    drain();

    // Random rays, mostly aimed triangles, some noise
    for (int phase = 0; phase < 8; phase++) begin
      for (int k = 0; k < 3; k++) begin
        cfg_write(cfg_reg_t'(REG_ORIGIN_X + k), jitter(1 << 22));
        cfg_write(cfg_reg_t'(REG_DIR_X + k),
                  ($urandom_range(0, 3) == 0) ? 0 : jitter(1 << 17));
      end
      cfg_write(REG_MIN_DIST, (phase == 6) ? 0 : $urandom_range(0, 1 << 16));
      cfg_write(REG_DET_THR, (phase == 7) ? 0 : $urandom_range(0, 64));
      ray_settings++;
      quiet = (phase == 4);
      if (phase == 2) long_hold = 1'b1;
      n = 0;
      while (n < 80) begin
        len = (phase == 2) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        aim = ($urandom_range(0, 9) < 8);
        for (int i = 0; i < len; i++) begin
          if (aim && $urandom_range(0, 9) != 0) send_triangle(aimed_tri(i == len - 1));
          else send_triangle(noise_tri(i == len - 1));
        end
        n += len;
      end
      in_valid <= 1'b0;
      drain();
      quiet = 1'b0;
    end

    $display("Sent %0d triangles in %0d batches under %0d ray settings; %0d batches hit.",
             triangles_sent, batches_sent, ray_settings, hits_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
